// ----- src/fsbtc_pkg.sv -----
// shared types and constants of the four-slot buffer tag cache
// no dependencies
package fsbtc_pkg;

  localparam int unsigned SlotCount = 4;
  localparam int unsigned SlotW     = 2;
  localparam int unsigned HistDepth = 10;
  localparam int unsigned ResW      = 48;
  localparam int unsigned InKeyW    = 48;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [SlotCount-1:0] FullSet = 4'hf;

  typedef logic [SlotW-1:0]     slot_t;
  typedef logic [SlotCount-1:0] slot_set_t;
  typedef slot_t                hist_t [HistDepth];

  // victim picker result
  typedef struct packed {
    slot_t victim;
    slot_t next_ptr;
  } victim_t;

endpackage

// ----- src/fsbtc_victim.sv -----
// replacement choice from the use history and the rotating pointer
// depends on fsbtc_pkg
module fsbtc_victim (
  input  fsbtc_pkg::hist_t   hist_i,
  input  fsbtc_pkg::slot_t   ptr_i,
  output fsbtc_pkg::victim_t pick_o
);
  import fsbtc_pkg::*;

  slot_set_t seen;
  slot_set_t grown;
  logic      stop;
  logic      found;
  slot_t     ptr_next;
  slot_t     cand;
  slot_t     victim;

  always_comb begin
    seen  = '0;
    grown = '0;
    stop  = 1'b0;
    // walk from the newest entry, stop before the one that would complete the set
    for (int k = 0; k < HistDepth; k++) begin
      grown = seen | (slot_set_t'(1) << hist_i[k]);
      if (!stop) begin
        if (grown == FullSet) begin
          stop = 1'b1;
        end else begin
          seen = grown;
        end
      end
    end
  end

  always_comb begin
    ptr_next = ptr_i + slot_t'(1);
    victim   = ptr_next;
    found    = 1'b0;
    cand     = '0;
    for (int i = 0; i < SlotCount; i++) begin
      cand = ptr_next + slot_t'(i);
      if (!found && !seen[cand]) begin
        victim = cand;
        found  = 1'b1;
      end
    end
  end

  assign pick_o.victim   = victim;
  assign pick_o.next_ptr = ptr_next;

endmodule

// ----- src/four_slot_buffer_tag_cache_core.sv -----
// top level of the four-slot buffer tag cache: key compare, state update, result register
// depends on fsbtc_pkg and fsbtc_victim
//
// One word in per cycle: busy stays low and a key may be started in every cycle. Each key
// gives one result, shown for one cycle: done rises with the result, which is taken through
// the input register, then the result register. The lookup, victim choice and state update
// for a key all happen between those registers, so every key sees the update of the key
// before it. Results cannot be stalled. The user must write slot resources through the cfg
// port only while no key is in flight; the block does not enforce this. Indexes above 3
// are ignored. No clearing pass after reset.
module four_slot_buffer_tag_cache_core #(
  parameter int unsigned KEY_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [fsbtc_pkg::InKeyW-1:0]   buffer_key_i,
  input  logic                           cfg_we_i,
  input  logic [fsbtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fsbtc_pkg::ResW-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [fsbtc_pkg::SlotW-1:0]    slot_o,
  output logic                           hit_o,
  output logic [fsbtc_pkg::ResW-1:0]     resource_o,
  output logic [fsbtc_pkg::CntW-1:0]     hit_total_o,
  output logic [fsbtc_pkg::CntW-1:0]     miss_total_o
);
  import fsbtc_pkg::*;

  logic [ResW-1:0]      res_q [SlotCount];
  logic [KEY_WIDTH-1:0] keys_q [SlotCount];
  hist_t                hist_q;
  slot_t                ptr_q;
  logic [CntW-1:0]      hit_cnt_q;
  logic [CntW-1:0]      miss_cnt_q;

  logic                 valid_q;
  logic [KEY_WIDTH-1:0] key_q;

  logic                 done_q;
  slot_t                slot_q;
  logic                 hit_q;
  logic [ResW-1:0]      resource_q;

  logic                 hit_w;
  slot_t                hit_slot_w;
  slot_t                slot_w;
  victim_t              pick_w;
  logic [CntW-1:0]      total_w;

  assign busy = 1'b0;

  // lowest matching slot wins
  always_comb begin
    hit_w      = 1'b0;
    hit_slot_w = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (keys_q[i] == key_q) begin
        hit_w      = 1'b1;
        hit_slot_w = slot_t'(i);
      end
    end
  end

  fsbtc_victim u_victim (
    .hist_i (hist_q),
    .ptr_i  (ptr_q),
    .pick_o (pick_w)
  );

  assign slot_w = hit_w ? hit_slot_w : pick_w.victim;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      key_q <= KEY_WIDTH'(buffer_key_i);
    end
  end

  // slot resources
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        res_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(SlotCount))) begin
      res_q[cfg_idx_i[SlotW-1:0]] <= cfg_wdata_i;
    end
  end

  // cache state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        keys_q[i] <= '0;
      end
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= '0;
      end
      ptr_q      <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (valid_q) begin
      if (hit_w) begin
        hit_cnt_q <= hit_cnt_q + CntW'(1);
      end else begin
        miss_cnt_q             <= miss_cnt_q + CntW'(1);
        ptr_q                  <= pick_w.next_ptr;
        keys_q[pick_w.victim]  <= key_q;
      end
      // push only when the slot differs from the newest entry
      if (hist_q[0] != slot_w) begin
        for (int k = HistDepth - 1; k > 0; k--) begin
          hist_q[k] <= hist_q[k-1];
        end
        hist_q[0] <= slot_w;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      slot_q     <= slot_w;
      hit_q      <= hit_w;
      resource_q <= res_q[slot_w];
    end
  end

  assign done_o       = done_q;
  assign slot_o       = slot_q;
  assign hit_o        = hit_q;
  assign resource_o   = resource_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

  assign total_w = hit_cnt_q + miss_cnt_q;

  a_slot_holds_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> keys_q[slot_o] == $past(key_q))
    else $error("reported slot does not hold the looked-up key");

  a_one_count_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> total_w == $past(total_w) + CntW'(1))
    else $error("hit plus miss count did not grow by one");

  a_counts_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(hit_cnt_q) && $stable(miss_cnt_q))
    else $error("counters changed without a result");

  a_history_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hist_q[0] == slot_o)
    else $error("newest history entry differs from reported slot");

endmodule
